@@ rtl/julian_day_ms_to_calendar_core_defines.svh @@
// Assertion macros for the Julian day to calendar core.
// Taken in by the top level; expects aclk and aresetn in the including scope.
`ifndef JULIAN_DAY_MS_TO_CALENDAR_CORE_DEFINES_SVH
`define JULIAN_DAY_MS_TO_CALENDAR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define JDMC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define JDMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jdmc_pkg.sv @@
// Shared constants, reciprocal multipliers and types for the calendar core.
// Used by jdmc_time_pipe, jdmc_date_pipe and the top level; no dependencies.
package jdmc_pkg;

    localparam int NUM_STAGES = 8;

    // Time-of-day constants.
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;

    // Calendar constants.
    localparam logic [24:0] GREG_START    = 25'd2299161;
    localparam logic [26:0] ALPHA_BIAS    = 27'd7468865;  // 4 * 1867216 + 1
    localparam logic [24:0] DAY_OFFSET    = 25'd1524;
    localparam logic [29:0] YEAR_SCALE    = 30'd20;
    localparam logic [29:0] YEAR_BIAS     = 30'd2442;
    localparam logic [24:0] DAYS_PER_YEAR = 25'd365;
    localparam logic [17:0] YEAR_OFFSET   = 18'd4715;

    // Division by a constant D is a multiply by ceil(2^S / D) and a shift by S,
    // with S chosen as numerator width plus ceil(log2(D)) so the quotient is exact.
    // The millisecond carry divides (ms >> 10) by 84375.
    localparam int          DAY_SHIFT = 38;
    localparam logic [22:0] RCP_DAY   =
        23'(((64'd1 << DAY_SHIFT) + 64'd84375 - 64'd1) / 64'd84375);

    localparam int          ALPHA_SHIFT = 44;
    localparam logic [27:0] RCP_ALPHA   =
        28'(((64'd1 << ALPHA_SHIFT) + 64'd146097 - 64'd1) / 64'd146097);

    localparam int          YEAR_SHIFT = 42;
    localparam logic [30:0] RCP_YEAR   =
        31'(((64'd1 << YEAR_SHIFT) + 64'd7305 - 64'd1) / 64'd7305);

    localparam int          HOUR_SHIFT = 49;
    localparam logic [28:0] RCP_HOUR   =
        29'(((64'd1 << HOUR_SHIFT) + 64'd3600000 - 64'd1) / 64'd3600000);

    localparam int          MIN_SHIFT = 38;
    localparam logic [23:0] RCP_MIN   =
        24'(((64'd1 << MIN_SHIFT) + 64'd60000 - 64'd1) / 64'd60000);

    // Entry k is ceil(30.6001 * k): the smallest day remainder giving month term k.
    // Apart from entry 0, none of these products is an integer, so floor(30.6001 * k) is one less.
    localparam logic [8:0] MONTH_EDGE [16] = '{
        9'd0,   9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215,
        9'd245, 9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } jdmc_ctrl_t;

endpackage

@@ rtl/jdmc_time_pipe.sv @@
// Time-of-day datapath: day carry, hour, minute and milliseconds in the minute.
// Depends on jdmc_pkg; stage loads come from the top-level handshake control.
module jdmc_time_pipe import jdmc_pkg::*; (
    input  logic        aclk,
    input  jdmc_ctrl_t  ctrl,
    input  logic [30:0] millis_i,
    output logic [4:0]  day_carry_o,
    output logic [4:0]  hour_o,
    output logic [5:0]  minute_o,
    output logic [15:0] millis_o
);

    logic [43:0] carry_prod;
    logic [30:0] carry_ms;
    logic [26:0] ms_rem_next;
    logic [55:0] hour_prod;
    logic [26:0] hour_ms;
    logic [21:0] r1_next;
    logic [45:0] min_prod;
    logic [21:0] min_ms;
    logic [15:0] msm_next;

    logic [30:0] ms0_reg;
    logic [4:0]  carry0_reg;
    logic [26:0] ms_rem1_reg;
    logic [26:0] ms_rem2_reg;
    logic [4:0]  hour2_reg;
    logic [21:0] r1_3_reg;
    logic [4:0]  hour3_reg;
    logic [21:0] r1_4_reg;
    logic [4:0]  hour4_reg;
    logic [5:0]  minute4_reg;
    logic [4:0]  hour5_reg, hour6_reg, hour7_reg;
    logic [5:0]  minute5_reg, minute6_reg, minute7_reg;
    logic [15:0] msm5_reg, msm6_reg, msm7_reg;

    // 86400000 = 1024 * 84375, so the low ten bits never affect the carry.
    assign carry_prod  = millis_i[30:10] * RCP_DAY;
    assign carry_ms    = 31'(carry0_reg) * 31'(MS_PER_DAY);
    assign ms_rem_next = 27'(ms0_reg - carry_ms);
    assign hour_prod   = ms_rem1_reg * RCP_HOUR;
    assign hour_ms     = 27'(hour2_reg) * 27'(MS_PER_HOUR);
    assign r1_next     = 22'(ms_rem2_reg - hour_ms);
    assign min_prod    = r1_3_reg * RCP_MIN;
    assign min_ms      = 22'(minute4_reg) * 22'(MS_PER_MIN);
    assign msm_next    = 16'(r1_4_reg - min_ms);

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            ms0_reg    <= millis_i;
            carry0_reg <= carry_prod[DAY_SHIFT +: 5];
        end
        if (ctrl.load[1]) begin
            ms_rem1_reg <= ms_rem_next;
        end
        if (ctrl.load[2]) begin
            ms_rem2_reg <= ms_rem1_reg;
            hour2_reg   <= hour_prod[HOUR_SHIFT +: 5];
        end
        if (ctrl.load[3]) begin
            r1_3_reg  <= r1_next;
            hour3_reg <= hour2_reg;
        end
        if (ctrl.load[4]) begin
            r1_4_reg    <= r1_3_reg;
            hour4_reg   <= hour3_reg;
            minute4_reg <= min_prod[MIN_SHIFT +: 6];
        end
        if (ctrl.load[5]) begin
            hour5_reg   <= hour4_reg;
            minute5_reg <= minute4_reg;
            msm5_reg    <= msm_next;
        end
        if (ctrl.load[6]) begin
            hour6_reg   <= hour5_reg;
            minute6_reg <= minute5_reg;
            msm6_reg    <= msm5_reg;
        end
        if (ctrl.load[7]) begin
            hour7_reg   <= hour6_reg;
            minute7_reg <= minute6_reg;
            msm7_reg    <= msm6_reg;
        end
    end

    assign day_carry_o = carry0_reg;
    assign hour_o      = hour7_reg;
    assign minute_o    = minute7_reg;
    assign millis_o    = msm7_reg;

endmodule

@@ rtl/jdmc_date_pipe.sv @@
// Calendar datapath: Julian day number plus carry to month, day and year.
// Depends on jdmc_pkg and on the day carry from jdmc_time_pipe.
module jdmc_date_pipe import jdmc_pkg::*; (
    input  logic         aclk,
    input  jdmc_ctrl_t   ctrl,
    input  logic [23:0]  julian_day_i,
    input  logic [4:0]   day_carry_i,
    output logic [3:0]   month_o,
    output logic [4:0]   day_o,
    output logic [16:0]  year_o
);

    logic [24:0]        d_next;
    logic [25:0]        alpha_num;
    logic [53:0]        alpha_prod;
    logic [24:0]        a_next;
    logic [24:0]        b_next;
    logic [28:0]        year_num;
    logic [59:0]        year_prod;
    logic [24:0]        cd_next;
    logic [8:0]         rem_next;
    logic [3:0]         e_next;
    logic [3:0]         mon_next;
    logic [4:0]         day_next;
    logic signed [17:0] yr_raw;
    logic signed [17:0] yr_next;

    logic [23:0] jd0_reg;
    logic [24:0] d1_reg, d2_reg;
    logic        greg1_reg, greg2_reg;
    logic [8:0]  alpha2_reg;
    logic [24:0] b3_reg, b4_reg;
    logic [15:0] c4_reg, c5_reg, c6_reg;
    logic [8:0]  rem5_reg, rem6_reg;
    logic [3:0]  e6_reg;
    logic [3:0]  month7_reg;
    logic [4:0]  day7_reg;
    logic [16:0] year7_reg;

    assign d_next     = 25'(jd0_reg) + 25'(day_carry_i);
    // Only meaningful on the Gregorian side, where it is positive.
    assign alpha_num  = 26'({d1_reg, 2'b00} - ALPHA_BIAS);
    assign alpha_prod = alpha_num * RCP_ALPHA;
    assign a_next     = greg2_reg ? d2_reg + 25'd1 + 25'(alpha2_reg) - 25'(alpha2_reg[8:2])
                                  : d2_reg;
    assign b_next     = a_next + DAY_OFFSET;
    assign year_num   = 29'(30'(b3_reg) * YEAR_SCALE - YEAR_BIAS);
    assign year_prod  = year_num * RCP_YEAR;
    assign cd_next    = 25'(c4_reg) * DAYS_PER_YEAR + 25'(c4_reg[15:2]);
    // The remainder always lies between 123 and 488 days.
    assign rem_next   = 9'(b4_reg - cd_next);

    always_comb begin
        e_next = '0;
        for (int k = 1; k < 16; k++) begin
            if (rem5_reg >= MONTH_EDGE[k]) begin
                e_next = e_next + 4'd1;
            end
        end
    end

    always_comb begin
        day_next = 5'(rem6_reg - MONTH_EDGE[e6_reg] + 9'd1);
        mon_next = (e6_reg > 4'd13) ? e6_reg - 4'd13 : e6_reg - 4'd1;
        yr_raw   = $signed({2'b00, c6_reg}) - $signed(YEAR_OFFSET)
                   - ((mon_next > 4'd2) ? 18'sd1 : 18'sd0);
        // There is no year zero: everything at or below it moves down by one.
        yr_next  = (yr_raw <= 18'sd0) ? yr_raw - 18'sd1 : yr_raw;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            jd0_reg <= julian_day_i;
        end
        if (ctrl.load[1]) begin
            d1_reg    <= d_next;
            greg1_reg <= (d_next >= GREG_START);
        end
        if (ctrl.load[2]) begin
            d2_reg     <= d1_reg;
            greg2_reg  <= greg1_reg;
            alpha2_reg <= alpha_prod[ALPHA_SHIFT +: 9];
        end
        if (ctrl.load[3]) begin
            b3_reg <= b_next;
        end
        if (ctrl.load[4]) begin
            b4_reg <= b3_reg;
            c4_reg <= year_prod[YEAR_SHIFT +: 16];
        end
        if (ctrl.load[5]) begin
            c5_reg   <= c4_reg;
            rem5_reg <= rem_next;
        end
        if (ctrl.load[6]) begin
            c6_reg   <= c5_reg;
            rem6_reg <= rem5_reg;
            e6_reg   <= e_next;
        end
        if (ctrl.load[7]) begin
            month7_reg <= mon_next;
            day7_reg   <= day_next;
            year7_reg  <= yr_next[16:0];
        end
    end

    assign month_o = month7_reg;
    assign day_o   = day7_reg;
    assign year_o  = year7_reg;

endmodule

@@ rtl/julian_day_ms_to_calendar_core.sv @@
// Top level of the Julian day to calendar core: handshake control and both datapaths.
// Depends on jdmc_pkg, jdmc_time_pipe, jdmc_date_pipe and the assertion macro header.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   s_       | in        | s_valid / s_ready  | s_julian_day, s_millis_of_day
//   m_       | out       | m_valid / m_ready  | m_month, m_day_of_month, m_year,
//            |           |                    | m_hour_of_day, m_minute_of_hour,
//            |           |                    | m_millis_in_minute
//
// One item enters per cycle unless a stalled output has every stage full.
// The eight register stages follow the chain of reciprocal multiplies on the date side.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// Each stage holds while the one after it is full and stalled, so a stalled output
// still lets items move up into empty stages behind it.
`include "julian_day_ms_to_calendar_core_defines.svh"

module julian_day_ms_to_calendar_core import jdmc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [23:0]  s_julian_day,
    input  logic [30:0]  s_millis_of_day,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [3:0]   m_month,
    output logic [4:0]   m_day_of_month,
    output logic [16:0]  m_year,
    output logic [4:0]   m_hour_of_day,
    output logic [5:0]   m_minute_of_hour,
    output logic [15:0]  m_millis_in_minute
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready_chain;
    logic [4:0]            day_carry;
    jdmc_ctrl_t            ctrl;

    // A stage may load when it is empty or when its item moves on this cycle.
    always_comb begin
        ready_chain[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            ready_chain[k] = !valid_reg[k] || ready_chain[k + 1];
        end
    end

    assign ctrl.load = ready_chain[NUM_STAGES-1:0];

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (ctrl.load[k]) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = ready_chain[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    jdmc_time_pipe u_time (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .millis_i    (s_millis_of_day),
        .day_carry_o (day_carry),
        .hour_o      (m_hour_of_day),
        .minute_o    (m_minute_of_hour),
        .millis_o    (m_millis_in_minute)
    );

    jdmc_date_pipe u_date (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .julian_day_i (s_julian_day),
        .day_carry_i  (day_carry),
        .month_o      (m_month),
        .day_o        (m_day_of_month),
        .year_o       (m_year)
    );

    `JDMC_ASSERT_IMPLY(a_month_range, m_valid, (m_month >= 4'd1) && (m_month <= 4'd12), "month out of range")
    `JDMC_ASSERT_IMPLY(a_time_range, m_valid, (m_day_of_month >= 5'd1) && (m_hour_of_day < 5'd24) && (m_minute_of_hour < 6'd60) && (m_millis_in_minute < 16'd60000), "day or time field out of range")
    `JDMC_ASSERT_IMPLY(a_no_year_zero, m_valid, m_year != 17'd0, "year zero produced")
    `JDMC_ASSERT_IMPLY(a_ready_needs_room, s_ready && m_valid && !m_ready, $countones(valid_reg) < NUM_STAGES, "input ready with a full stalled pipeline")
    `JDMC_ASSERT_NEXT(a_stall_keeps_item, m_valid && !m_ready && valid_reg[NUM_STAGES-2], valid_reg[NUM_STAGES-2], "item dropped behind a stalled output")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for julian_day_ms_to_calendar_core: directed and random Julian day items.
// Uses a clocked driver and monitor with an in-bench calendar predictor; needs only the RTL.
`timescale 1ns / 100ps

module tb;

    localparam longint MS_IN_DAY     = 86400000;
    localparam longint FIRST_GREG_JD = 2299161;
    localparam longint YEAR_ONE_JD   = 1721424;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     DRAIN_CYCLES  = 16;
    localparam int     PHASE_ITEMS   = 445;

    typedef struct {
        logic [23:0] jd;
        logic [30:0] ms;
    } stamp_t;

    typedef struct {
        logic [3:0]         month;
        logic [4:0]         dom;
        logic signed [16:0] year;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [15:0]        msm;
    } calendar_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_julian_day = '0;
    logic [30:0] s_millis_of_day = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [16:0] m_year;
    logic [4:0]  m_hour_of_day;
    logic [5:0]  m_minute_of_hour;
    logic [15:0] m_millis_in_minute;

    stamp_t    stamps_to_send[$];
    calendar_t dates_due[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        fault_count = 0;
    int        quiet_cycles = 0;

    julian_day_ms_to_calendar_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_julian_day       (s_julian_day),
        .s_millis_of_day    (s_millis_of_day),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_month            (m_month),
        .m_day_of_month     (m_day_of_month),
        .m_year             (m_year),
        .m_hour_of_day      (m_hour_of_day),
        .m_minute_of_hour   (m_minute_of_hour),
        .m_millis_in_minute (m_millis_in_minute)
    );

    // Calendar date and time of day for one Julian day and millisecond count.
    // Every numerator below is non-negative, so plain division is the floor.
    function automatic calendar_t calendar_of(logic [23:0] jd, logic [30:0] ms_in);
        longint    day_num, ms, alpha, a, b, c, rem, e, mon, dom, yr, secs, hr, mn;
        calendar_t r;
        day_num = longint'(jd) + longint'(ms_in) / MS_IN_DAY;
        ms      = longint'(ms_in) % MS_IN_DAY;
        if (day_num >= FIRST_GREG_JD) begin
            alpha = (4 * (day_num - 1867216) - 1) / 146097;
            a     = day_num + 1 + alpha - alpha / 4;
        end else begin
            a = day_num;
        end
        b   = a + 1524;
        c   = (20 * b - 2442) / 7305;
        rem = b - (365 * c + c / 4);
        e   = (10000 * rem) / 306001;
        dom = rem - (306001 * e) / 10000;
        mon = e - 1;
        if (mon > 12)
            mon -= 12;
        yr = c - 4715;
        if (mon > 2)
            yr -= 1;
        // There is no year zero: it and everything before it move down by one.
        if (yr <= 0)
            yr -= 1;
        secs = ms / 1000;
        hr   = secs / 3600;
        mn   = (secs - hr * 3600) / 60;
        r.month  = mon[3:0];
        r.dom    = dom[4:0];
        r.year   = yr[16:0];
        r.hour   = hr[4:0];
        r.minute = mn[5:0];
        r.msm    = 16'(ms - (hr * 3600 + mn * 60) * 1000);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] ERROR: %s", $realtime, what);
        fault_count++;
    endtask

    task automatic add_stamp(logic [23:0] jd, logic [30:0] ms);
        stamp_t st;
        st.jd = jd;
        st.ms = ms;
        stamps_to_send.push_back(st);
    endtask

    // Random items: mostly uniform, with a share aimed at the calendar switch,
    // the year-zero gap, whole-day carries and the top of the day range.
    task automatic add_random_stamps(int n);
        int          pick;
        logic [23:0] jd;
        logic [30:0] ms;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            jd   = 24'($urandom());
            ms   = 31'($urandom());
            if (pick >= 60 && pick < 75) begin
                jd = 24'(FIRST_GREG_JD - 400 + $urandom_range(0, 800));
                ms = 31'($urandom_range(0, 86399999));
            end else if (pick >= 75 && pick < 85) begin
                jd = 24'(YEAR_ONE_JD - 800 + $urandom_range(0, 1600));
                ms = 31'($urandom_range(0, 86399999));
            end else if (pick >= 85 && pick < 95) begin
                ms = 31'(longint'($urandom_range(1, 24)) * MS_IN_DAY - 2 + $urandom_range(0, 4));
            end else if (pick >= 95) begin
                jd = 24'hFFFFFF - 24'($urandom_range(0, 50));
                ms = 31'h7FFFFFFF - 31'($urandom_range(0, 200000000));
            end
            add_stamp(jd, ms);
        end
    endtask

    task automatic wait_all_done();
        while (stamps_to_send.size() != 0 || s_valid || dates_due.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Sender: offers the next pending item on a free slot unless it idles at random.
    always @(posedge aclk) begin
        stamp_t st;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (stamps_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                st = stamps_to_send.pop_front();
                s_valid         <= 1'b1;
                s_julian_day    <= st.jd;
                s_millis_of_day <= st.ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result first, then records the prediction for the
    // item taken in at the same edge, so the order never depends on the scheduler.
    always @(posedge aclk) begin
        calendar_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (dates_due.size() == 0) begin
                    report_mismatch("result arrived with no item outstanding");
                end else begin
                    want = dates_due.pop_front();
                    if (m_month !== want.month)
                        report_mismatch($sformatf("month %0d, expected %0d", m_month, want.month));
                    if (m_day_of_month !== want.dom)
                        report_mismatch($sformatf("day %0d, expected %0d",
                                                  m_day_of_month, want.dom));
                    if (m_year !== want.year)
                        report_mismatch($sformatf("year %0d, expected %0d",
                                                  $signed(m_year), want.year));
                    if (m_hour_of_day !== want.hour)
                        report_mismatch($sformatf("hour %0d, expected %0d",
                                                  m_hour_of_day, want.hour));
                    if (m_minute_of_hour !== want.minute)
                        report_mismatch($sformatf("minute %0d, expected %0d",
                                                  m_minute_of_hour, want.minute));
                    if (m_millis_in_minute !== want.msm)
                        report_mismatch($sformatf("millis in minute %0d, expected %0d",
                                                  m_millis_in_minute, want.msm));
                end
            end
            if (s_valid && s_ready)
                dates_due.push_back(calendar_of(s_julian_day, s_millis_of_day));
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed items: field extremes, the calendar switch, the year-zero gap
        // and the edges of minutes, hours and days.
        add_stamp(24'd0, 31'd0);
        add_stamp(24'hFFFFFF, 31'h7FFFFFFF);
        add_stamp(24'hFFFFFF, 31'd0);
        add_stamp(24'd0, 31'h7FFFFFFF);
        add_stamp(24'd2299159, 31'd0);
        add_stamp(24'd2299160, 31'd86399999);
        add_stamp(24'd2299160, 31'd86400000);
        add_stamp(24'd2299161, 31'd0);
        add_stamp(24'd1721423, 31'd0);
        add_stamp(24'd1721424, 31'd0);
        add_stamp(24'd1721422, 31'd86400000);
        add_stamp(24'd2451545, 31'd43200000);
        add_stamp(24'd2451604, 31'd1);
        add_stamp(24'd2440588, 31'd59999);
        add_stamp(24'd2440588, 31'd60000);
        add_stamp(24'd2440588, 31'd3599999);
        add_stamp(24'd2440588, 31'd3600000);
        add_stamp(24'd2440587, 31'd2073600000);
        add_stamp(24'hAAAAAA, 31'h55555555);
        add_stamp(24'h555555, 31'h2AAAAAAA);
        wait_all_done();

        // Each phase starts only once the previous one has fully drained.
        add_random_stamps(PHASE_ITEMS);
        wait_all_done();

        send_idle_pct <= 54;
        add_random_stamps(PHASE_ITEMS);
        wait_all_done();

        send_idle_pct  <= 0;
        recv_stall_pct <= 54;
        add_random_stamps(PHASE_ITEMS);
        wait_all_done();

        send_idle_pct  <= 12;
        recv_stall_pct <= 12;
        add_random_stamps(PHASE_ITEMS);
        wait_all_done();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
